### rtl/lif_pkg.sv
// Package for the leaky integrate-and-fire neuron array: field widths,
// beat layouts and configuration register indexes.
// No dependencies; imported by leaky_integrate_fire_neurons.
package lif_pkg;

    localparam int IDX_W      = 13;
    localparam int VAL_W      = 24;
    localparam int LEAK_W     = 16;
    localparam int THR_W      = 23;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 23;

    // Input beat: neuron_index then input_current, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    // Output beat: spike_out, membrane, spike_now, padded to whole bytes.
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_LEAK_FACTOR    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRE_THRESHOLD = 1'd1;

    localparam logic [LEAK_W-1:0] LEAK_RESET = 16'd58982;
    localparam logic [THR_W-1:0]  THR_RESET  = 23'd4096;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // One stored neuron: pending spike above the membrane.
    typedef struct packed {
        logic                    spike;
        logic signed [VAL_W-1:0] membrane;
    } t_neuron;

endpackage

### rtl/leaky_integrate_fire_neurons.sv
// Leaky integrate-and-fire neuron array with subtractive reset and delayed spike.
// Neuron state is held in one synchronous RAM; depends on lif_pkg.
//
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: neuron_index[12:0], input_current[36:13]; tuser: command
// m_axis   | out       | tdata: spike_out[0], membrane[24:1], spike_now[25]
// cfg      | in        | i_cfg_addr 0 leak_factor, 1 fire_threshold; no read-back
//
// One beat per cycle is accepted while no stall or pending clear holds the input. A beat's
// result passes the RAM read, the multiply and the add/saturate/threshold stage into the
// output register. An update to the same neuron as the beat directly ahead waits in the
// multiply stage for the write-back. Reset and every clear command run a sweep over all
// NEURONS addresses that zeroes the RAM; no beat is accepted until it ends. Output stalls
// back up through the stages only as far as they are full.
module leaky_integrate_fire_neurons #(
    parameter int NEURONS = 8192
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // neuron_index [12:0], input_current [36:13], zero [39:37]
    input  logic [lif_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command [0]
    input  logic [lif_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // spike_out [0], membrane [24:1], spike_now [25], zero [31:26]
    output logic [lif_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [lif_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [lif_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import lif_pkg::*;

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int EW = (AW > IDX_W) ? AW : IDX_W;
    localparam int PW = VAL_W + LEAK_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

    // Configuration.
    logic [LEAK_W-1:0] r_leak;
    logic [THR_W-1:0]  r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak <= LEAK_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LEAK_FACTOR:    r_leak <= i_cfg_wdata[LEAK_W-1:0];
                CFG_FIRE_THRESHOLD: r_thr  <= i_cfg_wdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input decode.
    logic                    in_cmd;
    logic [IDX_W-1:0]        in_idx;
    logic signed [VAL_W-1:0] in_cur;
    logic [EW-1:0]           in_idx_ext;
    logic [AW-1:0]           in_addr;
    logic                    in_upd;
    logic                    in_acc;

    assign in_cmd     = s_axis_tuser[0];
    assign in_idx     = s_axis_tdata[IDX_W-1:0];
    assign in_cur     = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
    assign in_idx_ext = EW'(in_idx);
    assign in_addr    = in_idx_ext[AW-1:0];
    assign in_upd     = (in_cmd == CMD_UPDATE) && (32'(in_idx) < NEURONS);

    // Pipeline registers.
    logic                    r_p1_v, r_p1_upd, r_p1_clr, r_p1_fwd_v;
    logic [AW-1:0]           r_p1_addr;
    logic signed [VAL_W-1:0] r_p1_cur;
    t_neuron                 r_p1_fwd;
    t_neuron                 r_mem_q;

    logic                    r_p2_v, r_p2_upd, r_p2_clr, r_p2_prev;
    logic [AW-1:0]           r_p2_addr;
    logic signed [VAL_W-1:0] r_p2_cur;
    logic signed [PW-1:0]    r_p2_prod;

    logic                    r_o_valid;
    logic [OUT_TDATA_W-1:0]  r_o_data;

    logic                    r_sweep, r_clr_pend;
    logic [AW-1:0]           r_sweep_addr;

    // Stage movement.
    logic out_free, mv2, p2_free, p2_hit, mv1, p1_free;

    assign out_free = !r_o_valid || m_axis_tready;
    assign mv2      = r_p2_v && out_free;
    assign p2_free  = !r_p2_v || mv2;
    // The multiply waits while the stage ahead still holds the same neuron.
    assign p2_hit   = r_p2_v && r_p2_upd && r_p1_upd && (r_p2_addr == r_p1_addr);
    assign mv1      = r_p1_v && p2_free && !p2_hit;
    assign p1_free  = !r_p1_v || mv1;

    assign s_axis_tready = p1_free && !r_clr_pend;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Stage two arithmetic: floor shift, add, saturate, threshold.
    logic signed [PW-17:0]  dec;
    logic signed [VAL_W+1:0] sum;
    logic signed [VAL_W-1:0] sat;
    logic signed [VAL_W+1:0] diff;
    logic                    fire;
    t_neuron                 res;

    always_comb begin
        dec  = r_p2_prod[PW-1:16];
        sum  = (VAL_W+2)'(dec) + (VAL_W+2)'(r_p2_cur);
        if (sum > (VAL_W+2)'(24'sh7FFFFF)) begin
            sat = 24'sh7FFFFF;
        end else if (sum < -(VAL_W+2)'(26'sh800000)) begin
            sat = 24'sh800000;
        end else begin
            sat = sum[VAL_W-1:0];
        end
        diff = (VAL_W+2)'(sat) - (VAL_W+2)'({1'b0, r_thr});
        fire = !diff[VAL_W+1];
        res.spike    = fire;
        res.membrane = fire ? diff[VAL_W-1:0] : sat;
    end

    // Stage one operand: RAM word or the value written since it was read.
    t_neuron                 opnd;
    logic signed [PW-1:0]    prod;
    logic                    wr_hit_in, wr_hit_p1;

    assign opnd      = r_p1_fwd_v ? r_p1_fwd : r_mem_q;
    assign prod      = PW'(opnd.membrane) * PW'($signed({1'b0, r_leak}));
    assign wr_hit_in = mv2 && r_p2_upd && in_upd && (r_p2_addr == in_addr);
    assign wr_hit_p1 = mv2 && r_p2_upd && r_p1_upd && (r_p2_addr == r_p1_addr);

    // Neuron RAM.
    t_neuron mem [NEURONS];
    logic    mem_we;
    logic [AW-1:0] mem_waddr;
    t_neuron mem_wdata;

    assign mem_we    = r_sweep || (mv2 && r_p2_upd);
    assign mem_waddr = r_sweep ? r_sweep_addr : r_p2_addr;
    assign mem_wdata = r_sweep ? t_neuron'('0) : res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem_q <= mem[in_addr];
        end
    end

    // Control state.
    logic sweep_done;
    assign sweep_done = r_sweep && (r_sweep_addr == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_sweep      <= 1'b1;
            r_clr_pend   <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            if (in_acc) begin
                r_p1_v <= 1'b1;
            end else if (mv1) begin
                r_p1_v <= 1'b0;
            end
            if (mv1) begin
                r_p2_v <= 1'b1;
            end else if (mv2) begin
                r_p2_v <= 1'b0;
            end
            if (mv2) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            // A clear sweeps the RAM once every earlier beat has written back.
            if (in_acc && in_cmd == CMD_CLEAR) begin
                r_clr_pend <= 1'b1;
            end else if (sweep_done) begin
                r_clr_pend <= 1'b0;
            end
            if (mv2 && r_p2_clr) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (sweep_done) begin
                r_sweep <= 1'b0;
            end else if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_upd   <= in_upd;
            r_p1_clr   <= (in_cmd == CMD_CLEAR);
            r_p1_addr  <= in_addr;
            r_p1_cur   <= in_cur;
            r_p1_fwd_v <= wr_hit_in;
            r_p1_fwd   <= res;
        end else if (wr_hit_p1) begin
            r_p1_fwd_v <= 1'b1;
            r_p1_fwd   <= res;
        end
        if (mv1) begin
            r_p2_upd  <= r_p1_upd;
            r_p2_clr  <= r_p1_clr;
            r_p2_addr <= r_p1_addr;
            r_p2_cur  <= r_p1_cur;
            r_p2_prod <= prod;
            r_p2_prev <= opnd.spike;
        end
        if (mv2) begin
            if (r_p2_upd) begin
                r_o_data <= {6'd0, res.spike, res.membrane, r_p2_prev};
            end else begin
                r_o_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

### verif/tb_leaky_integrate_fire_neurons.sv
// Self-checking testbench for leaky_integrate_fire_neurons: streams update and clear
// beats under random bursts and output stalls, predicts each result with its own neuron
// model and checks it field by field. Depends on lif_pkg and the neuron array RTL.
module tb_leaky_integrate_fire_neurons;
    import lif_pkg::*;

    localparam int     NEURON_COUNT = 8192;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     PHASE_ITEMS  = 125;
    localparam int     PHASES       = 6;
    localparam longint VAL_MAX      = 8388607;
    localparam longint VAL_MIN      = -8388608;

    typedef struct {
        logic                    command;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] current;
    } t_update_beat;

    typedef struct {
        logic                    spike_prev;
        logic signed [VAL_W-1:0] membrane;
        logic                    spike_now;
    } t_neuron_result;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_QUARTER,
        READY_LONG_STALL
    } t_stall_mode;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // Predicted neuron state and configuration.
    logic signed [VAL_W-1:0] membrane_model [NEURON_COUNT];
    logic                    spike_model [NEURON_COUNT];
    logic [LEAK_W-1:0]       leak_model      = LEAK_RESET;
    logic [THR_W-1:0]        threshold_model = THR_RESET;

    t_update_beat   pending_beats [$];
    t_neuron_result expected_results [$];
    logic [IDX_W-1:0] neuron_pool [8];

    logic        beat_taken   = 1'b0;
    int          gap_left     = 0;
    int          burst_left   = 1;
    int          cycle_count  = 0;
    int          error_count  = 0;
    int          results_seen = 0;
    int          stall_left   = 0;
    int          stall_tick   = 0;
    t_stall_mode stall_mode   = READY_ALWAYS;

    leaky_integrate_fire_neurons #(
        .NEURONS(NEURON_COUNT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_neuron_result integrate_neuron(input t_update_beat beat);
        t_neuron_result res;
        longint         total;
        res.spike_prev = 1'b0;
        res.membrane   = '0;
        res.spike_now  = 1'b0;
        if (beat.command == CMD_CLEAR) begin
            for (int n = 0; n < NEURON_COUNT; n++) begin
                membrane_model[n] = '0;
                spike_model[n]    = 1'b0;
            end
            return res;
        end
        if (beat.idx >= NEURON_COUNT) return res;
        // An arithmetic shift of the signed product rounds towards minus infinity.
        total = (longint'(membrane_model[beat.idx]) * longint'(leak_model)) >>> 16;
        total = total + longint'(beat.current);
        if (total > VAL_MAX) total = VAL_MAX;
        if (total < VAL_MIN) total = VAL_MIN;
        res.spike_now = (total >= longint'(threshold_model));
        if (res.spike_now) total = total - longint'(threshold_model);
        res.spike_prev = spike_model[beat.idx];
        res.membrane   = total[VAL_W-1:0];
        membrane_model[beat.idx] = total[VAL_W-1:0];
        spike_model[beat.idx]    = res.spike_now;
        return res;
    endfunction

    function automatic t_update_beat random_beat();
        t_update_beat b;
        longint       span;
        longint       value;
        int           pick;
        b.command = ($urandom_range(0, 149) == 0) ? CMD_CLEAR : CMD_UPDATE;
        // Most updates revisit a few neurons so that the membranes build up.
        pick  = $urandom_range(0, 9);
        b.idx = (pick < 7) ? neuron_pool[$urandom_range(0, 7)] : IDX_W'($urandom);
        span  = (threshold_model < 64) ? 64 : longint'(threshold_model);
        pick  = $urandom_range(0, 9);
        if (pick < 6) begin
            value = longint'($urandom_range(0, 32'(3 * span))) - span;
            if (value > VAL_MAX) value = VAL_MAX;
            b.current = value[VAL_W-1:0];
        end else if (pick < 9) begin
            b.current = VAL_W'($urandom);
        end else begin
            b.current = $urandom_range(0, 1) ? VAL_W'(VAL_MAX) : VAL_W'(VAL_MIN);
        end
        return b;
    endfunction

    task automatic queue_beat(input logic command, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] current);
        t_update_beat b;
        b.command = command;
        b.idx     = idx;
        b.current = current;
        pending_beats.push_back(b);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_LEAK_FACTOR) leak_model = value[LEAK_W-1:0];
        else threshold_model = value[THR_W-1:0];
    endtask

    // Waits until the sender has run dry and every expected result has come, then lets the
    // pipeline settle.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Driver: bursts of beats with random gaps between them.
    always @(negedge i_clk) begin
        t_update_beat next_beat;
        if (i_rst_n && (!s_axis_tvalid || beat_taken)) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                next_beat = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_TDATA_W - IDX_W - VAL_W){1'b0}},
                                  next_beat.current, next_beat.idx};
                s_axis_tuser  <= next_beat.command;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: ready follows a stall pattern that is drawn anew at random.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = 64;
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            READY_ALWAYS:  m_axis_tready <= 1'b1;
            READY_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
            READY_QUARTER: m_axis_tready <= (stall_tick % 4 == 0);
            default:       m_axis_tready <= (stall_tick % 16 >= 12);
        endcase
    end

    // Monitor: predicts on every accepted input beat and checks every output beat.
    always @(posedge i_clk) begin
        t_update_beat   beat;
        t_neuron_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            beat_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                beat.command = s_axis_tuser[0];
                beat.idx     = s_axis_tdata[IDX_W-1:0];
                beat.current = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
                expected_results.push_back(integrate_neuron(beat));
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing expected, membrane",
                                    longint'($signed(m_axis_tdata[VAL_W:1])), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[0] !== want.spike_prev)
                        report_mismatch("spike_out", longint'(m_axis_tdata[0]),
                                        longint'(want.spike_prev));
                    if (m_axis_tdata[VAL_W:1] !== want.membrane)
                        report_mismatch("membrane", longint'($signed(m_axis_tdata[VAL_W:1])),
                                        longint'(want.membrane));
                    if (m_axis_tdata[VAL_W+1] !== want.spike_now)
                        report_mismatch("spike_now", longint'(m_axis_tdata[VAL_W+1]),
                                        longint'(want.spike_now));
                end
                results_seen++;
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] leak_val;
        logic [CFG_DATA_W-1:0] thr_val;
        for (int n = 0; n < NEURON_COUNT; n++) begin
            membrane_model[n] = '0;
            spike_model[n]    = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration.
        @(posedge i_clk);
        queue_beat(CMD_UPDATE, 13'd0, 24'sd0);
        queue_beat(CMD_UPDATE, 13'd0, 24'sd4096);       // exactly at the threshold
        queue_beat(CMD_UPDATE, 13'd0, 24'sd0);          // previous spike comes back
        queue_beat(CMD_UPDATE, 13'd8191, VAL_W'(VAL_MAX));
        queue_beat(CMD_UPDATE, 13'd8191, VAL_W'(VAL_MAX)); // saturates high
        queue_beat(CMD_UPDATE, 13'd5, VAL_W'(VAL_MIN));
        queue_beat(CMD_UPDATE, 13'd5, VAL_W'(VAL_MIN));    // saturates low
        queue_beat(CMD_UPDATE, 13'd5, -24'sd1);
        queue_beat(CMD_UPDATE, 13'h1555, 24'h555555);
        queue_beat(CMD_UPDATE, 13'h0AAA, 24'hAAAAAA);
        // Back-to-back updates of one neuron exercise the write-back forwarding.
        queue_beat(CMD_UPDATE, 13'd7, 24'sd3000);
        queue_beat(CMD_UPDATE, 13'd7, 24'sd3000);
        queue_beat(CMD_UPDATE, 13'd7, 24'sd3000);
        queue_beat(CMD_UPDATE, 13'd8, -24'sd3);
        queue_beat(CMD_UPDATE, 13'd8, -24'sd3);         // small negative decay is floored
        queue_beat(CMD_CLEAR, 13'd8191, -24'sd1);
        queue_beat(CMD_UPDATE, 13'd8191, 24'sd0);
        queue_beat(CMD_UPDATE, 13'd5, 24'sd0);
        queue_beat(CMD_UPDATE, 13'd0, 24'sd4095);       // just below the threshold
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin leak_val = 23'd65535; thr_val = 23'd1; end
                1: begin leak_val = 23'd0; thr_val = 23'd8388607; end
                2: begin
                    leak_val = 23'($urandom_range(0, 65535));
                    thr_val  = 23'($urandom_range(1, 100000));
                end
                3: begin leak_val = 23'd32768; thr_val = 23'd4096; end
                4: begin
                    leak_val = 23'($urandom_range(0, 65535));
                    thr_val  = 23'($urandom_range(1, 8388607));
                end
                default: begin leak_val = 23'(LEAK_RESET); thr_val = 23'(THR_RESET); end
            endcase
            write_register(CFG_LEAK_FACTOR, leak_val);
            write_register(CFG_FIRE_THRESHOLD, thr_val);
            neuron_pool[0] = '0;
            neuron_pool[1] = IDX_W'(NEURON_COUNT - 1);
            for (int k = 2; k < 8; k++) neuron_pool[k] = IDX_W'($urandom);
            @(posedge i_clk);
            for (int k = 0; k < PHASE_ITEMS; k++) pending_beats.push_back(random_beat());
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
